FILE: sv/mg1qde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mg1qde_pkg: shared types and constants of the M/G/1 queue delay estimator
// Field widths, derived datapath widths, word structs and the command and
// status groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package mg1qde_pkg;

   // time base: arrival times are taken modulo 2^TIME_BITS
   localparam int unsigned TIME_BITS   = 32;

   // field and state widths
   localparam int unsigned ARR_FIELD_W = 32;
   localparam int unsigned SVC_W       = 16;
   localparam int unsigned WAIT_W      = 32;
   localparam int unsigned COUNT_W     = 32;
   localparam int unsigned SUM_BITS    = 48;
   localparam int unsigned SQ_W        = 64;
   localparam int unsigned FINISH_BITS = TIME_BITS + 8;

   // usable arrival bits
   localparam int unsigned ARR_W = (TIME_BITS < ARR_FIELD_W) ? TIME_BITS : ARR_FIELD_W;

   // square of one service length
   localparam int unsigned SQR_W = 2 * SVC_W;

   // utilisation clamp: 0.999 / (1 - 0.999) * 0.5 gives 999 / 2
   localparam int unsigned           CLAMP_W   = 10;
   localparam logic [CLAMP_W-1:0]    CLAMP_NUM = 10'd999;

   // divider widths: numerator holds 999 * Q, denominator holds 2 (T - S) or 2 S
   localparam int unsigned NUM_W  = SQ_W + CLAMP_W;
   localparam int unsigned DIFF_W = (FINISH_BITS > SUM_BITS) ? FINISH_BITS : SUM_BITS;
   localparam int unsigned DEN_W  = DIFF_W + 1;
   localparam int unsigned CNT_W  = $clog2(NUM_W);

   // finish time sum arr + wait + svc, and the width it is compared at
   localparam int unsigned FIN_SUM_W = ((ARR_W > WAIT_W) ? ARR_W : WAIT_W) + 2;
   localparam int unsigned CMP_W     = (FIN_SUM_W > FINISH_BITS) ? FIN_SUM_W : FINISH_BITS;

   // input word
   typedef struct packed {
      logic [ARR_FIELD_W-1:0] arrival_time;
      logic [SVC_W-1:0]       service_len;
   } mg1qde_req_type;

   // result word
   typedef struct packed {
      logic [WAIT_W-1:0] wait_estimate;
      logic              bad_input;
   } mg1qde_rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic setup;
      logic div_step;
      logic round;
      logic update;
      logic finish;
      logic load_out;
   } mg1qde_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic bad;
      logic empty;
      logic div_last;
      logic out_free;
   } mg1qde_sts_type;

endpackage : mg1qde_pkg
`default_nettype wire

FILE: sv/mg1_queue_delay_estimator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mg1_queue_delay_estimator_top: M/G/1 queue wait estimator
// Returns the Pollaczek-Khinchine mean wait from running packet statistics,
// then records the packet; a zero service length is flagged, not recorded.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one word per packet (arrival time, service length), taken
//   when req_valid is high and req_stall is low. rsp channel: one word per
//   packet (wait estimate, bad input flag), taken when rsp_valid is high and
//   rsp_stall is low.
//   Order: a normal packet goes through check, the 74-step radix-2 divider,
//   round, update and finish, then its result is loaded out and the next
//   word can be taken. With no recorded history the divider and round are
//   skipped; a zero service length goes from check straight to loading out.
//   One word is worked on at a time; req_stall is high while busy.
//   A finished result sits in the output register; a new word may be taken
//   while it waits. If the receiver stalls, the next result is held inside
//   until the output register frees, and no further word is taken.
//   Reset clears the count, the sums and the latest finish time, so the
//   first estimate is 0, and empties the output register.
// ----------------------------------------------------------------------------
module mg1_queue_delay_estimator_top
   import mg1qde_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire mg1qde_req_type req_data,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output mg1qde_rsp_type      rsp_data
);

   mg1qde_cmd_type cmd;
   mg1qde_sts_type sts;

   // sequencer
   mg1qde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // statistics, divider and output register
   mg1qde_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule : mg1_queue_delay_estimator_top
`default_nettype wire

FILE: sv/mg1qde_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mg1qde_ctrl: sequencer of the queue delay estimator
// One-hot state machine taking one word at a time; with history it steps the
// divider and rounds, records a valid packet, loads the output register.
// ----------------------------------------------------------------------------
module mg1qde_ctrl
   import mg1qde_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire mg1qde_sts_type sts,
   output mg1qde_cmd_type      cmd
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CHECK  = 7'b0000010,
      ST_DIVIDE = 7'b0000100,
      ST_ROUND  = 7'b0001000,
      ST_UPDATE = 7'b0010000,
      ST_FINISH = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // take a new word only while idle
   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.setup = 1'b1;
            if (sts.bad) begin
               state_in = ST_DONE;
            end else if (sts.empty) begin
               state_in = ST_UPDATE;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule : mg1qde_ctrl
`default_nettype wire

FILE: sv/mg1qde_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mg1qde_dp: datapath of the queue delay estimator
// Running statistics, operand setup, radix-2 restoring divider, ceiling and
// saturation, packet recording and the output register.
// ----------------------------------------------------------------------------
module mg1qde_dp
   import mg1qde_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire mg1qde_cmd_type cmd,
   output mg1qde_sts_type      sts,
   input  wire mg1qde_req_type req_data,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output mg1qde_rsp_type      rsp_data
);

   // running statistics
   logic [COUNT_W-1:0]     count_ff,  count_in;
   logic [SUM_BITS-1:0]    ssum_ff,   ssum_in;
   logic [SQ_W-1:0]        sqsum_ff,  sqsum_in;
   logic [FINISH_BITS-1:0] latest_ff, latest_in;

   // captured word and work registers
   logic [ARR_W-1:0]       arr_ff,    arr_in;
   logic [SVC_W-1:0]       svc_ff,    svc_in;
   logic [NUM_W-1:0]       num_ff,    num_in;
   logic [DEN_W-1:0]       den_ff,    den_in;
   logic [DEN_W-1:0]       rem_ff,    rem_in;
   logic [CNT_W-1:0]       cnt_ff,    cnt_in;
   logic [WAIT_W-1:0]      wait_ff,   wait_in;
   logic [FIN_SUM_W-1:0]   fin_ff,    fin_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   mg1qde_rsp_type         rsp_data_ff,  rsp_data_in;

   // operand setup
   logic [DIFF_W-1:0]      t_ext;
   logic [DIFF_W-1:0]      s_ext;
   logic [DIFF_W-1:0]      diff;
   logic                   over;
   logic [NUM_W-1:0]       num_clamp;

   // divider step
   logic [DEN_W:0]         partial;
   logic [DEN_W:0]         den_wide;
   logic [DEN_W:0]         partial_sub;
   logic                   fits;

   // rounding
   logic                   quo_high;
   logic                   inc;
   logic [WAIT_W:0]        quo_up;

   // recording
   logic [SQR_W-1:0]       sq;
   logic [SQ_W:0]          sqsum_add;
   logic [SUM_BITS:0]      ssum_add;
   logic [CMP_W-1:0]       fin_ext;
   logic [CMP_W-1:0]       fin_max;
   logic [CMP_W-1:0]       fin_clamp;

   // status to the controller
   assign sts.bad      = (svc_ff == '0);
   assign sts.empty    = (count_ff == '0) || (ssum_ff == '0);
   assign sts.div_last = (cnt_ff == '0);
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   // operands: wait = ceil(Q / 2(T-S)), or ceil(999 Q / 2S) once overloaded
   assign t_ext     = DIFF_W'(latest_ff);
   assign s_ext     = DIFF_W'(ssum_ff);
   assign over      = (t_ext > s_ext);
   assign diff      = t_ext - s_ext;
   assign num_clamp = NUM_W'(sqsum_ff) * NUM_W'(CLAMP_NUM);

   // one restoring divide step: quotient bits shift in behind the numerator
   assign partial     = {rem_ff, num_ff[NUM_W-1]};
   assign den_wide    = {1'b0, den_ff};
   assign fits        = (partial >= den_wide);
   assign partial_sub = partial - den_wide;

   // round up and saturate the quotient
   assign quo_high = (num_ff[NUM_W-1:WAIT_W] != '0);
   assign inc      = (rem_ff != '0);
   assign quo_up   = {1'b0, num_ff[WAIT_W-1:0]} + (WAIT_W + 1)'(inc);

   // saturating sums
   assign sq        = SQR_W'(svc_ff) * SQR_W'(svc_ff);
   assign sqsum_add = {1'b0, sqsum_ff} + (SQ_W + 1)'(sq);
   assign ssum_add  = {1'b0, ssum_ff} + (SUM_BITS + 1)'(svc_ff);

   // clamp the finish time to its width
   assign fin_ext   = CMP_W'(fin_ff);
   assign fin_max   = CMP_W'({FINISH_BITS{1'b1}});
   assign fin_clamp = (fin_ext > fin_max) ? fin_max : fin_ext;

   // next values
   always_comb begin
      count_in     = count_ff;
      ssum_in      = ssum_ff;
      sqsum_in     = sqsum_ff;
      latest_in    = latest_ff;
      arr_in       = arr_ff;
      svc_in       = svc_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      wait_in      = wait_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // hold the accepted word
      if (cmd.capture) begin
         arr_in = req_data.arrival_time[ARR_W-1:0];
         svc_in = req_data.service_len;
      end

      // load divider operands, clear the estimate
      if (cmd.setup) begin
         wait_in = '0;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W - 1);
         if (over) begin
            num_in = NUM_W'(sqsum_ff);
            den_in = {diff, 1'b0};
         end else begin
            num_in = num_clamp;
            den_in = {s_ext, 1'b0};
         end
      end

      // advance the divider one bit
      if (cmd.div_step) begin
         num_in = {num_ff[NUM_W-2:0], fits};
         rem_in = fits ? partial_sub[DEN_W-1:0] : partial[DEN_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
      end

      // ceiling, saturate at the result width
      if (cmd.round) begin
         if (quo_high || quo_up[WAIT_W]) begin
            wait_in = '1;
         end else begin
            wait_in = quo_up[WAIT_W-1:0];
         end
      end

      // record the packet
      if (cmd.update) begin
         sqsum_in = sqsum_add[SQ_W] ? '1 : sqsum_add[SQ_W-1:0];
         ssum_in  = ssum_add[SUM_BITS] ? '1 : ssum_add[SUM_BITS-1:0];
         if (count_ff != '1) begin
            count_in = count_ff + COUNT_W'(1);
         end
         fin_in = FIN_SUM_W'(arr_ff) + FIN_SUM_W'(wait_ff) + FIN_SUM_W'(svc_ff);
      end

      // keep the latest finish time
      if (cmd.finish) begin
         if (fin_clamp > CMP_W'(latest_ff)) begin
            latest_in = FINISH_BITS'(fin_clamp);
         end
      end

      // drop a taken word, load a new one
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.wait_estimate = wait_ff;
         rsp_data_in.bad_input     = sts.bad;
      end
   end

   // statistics and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ssum_ff      <= '0;
         sqsum_ff     <= '0;
         latest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ssum_ff      <= ssum_in;
         sqsum_ff     <= sqsum_in;
         latest_ff    <= latest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // work and payload registers
   always_ff @(posedge clock) begin
      arr_ff      <= arr_in;
      svc_ff      <= svc_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      wait_ff     <= wait_in;
      fin_ff      <= fin_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule : mg1qde_dp
`default_nettype wire

FILE: sim/mg1qde_wait_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mg1qde_wait_checker: result predictor and scoreboard for the estimator
// Watches both channels of the M/G/1 queue delay estimator. Every accepted
// packet word is run through a local model of the running statistics; every
// accepted result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mg1qde_wait_checker
   import mg1qde_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_stall,
   input  wire mg1qde_req_type req_data,
   input  wire logic           rsp_valid,
   input  wire logic           rsp_stall,
   input  wire mg1qde_rsp_type rsp_data,
   output int                  fail_count,
   output int                  pending_words,
   output int                  packets_seen,
   output int                  empty_hits,
   output int                  flagged_hits,
   output int                  clamp_hits,
   output int                  sat_hits
);

   localparam bit [63:0] WAIT_CEIL   = (64'd1 << WAIT_W) - 64'd1;
   localparam bit [63:0] SUM_CEIL    = (64'd1 << SUM_BITS) - 64'd1;
   localparam bit [63:0] FINISH_CEIL = (64'd1 << FINISH_BITS) - 64'd1;
   // 0.999 utilization: rho / (1 - rho) / 2 = 999 / 2
   localparam bit [63:0] UTIL_NUM    = 64'd999;
   localparam int        PRINT_LIMIT = 100;

   // running statistics of recorded packets
   bit [COUNT_W-1:0] pkt_count;
   bit [63:0]        svc_total;
   bit [63:0]        svc_sq_total;
   bit [63:0]        finish_max;

   mg1qde_rsp_type   expected_rsp[$];
   mg1qde_rsp_type   due_rsp;
   int               results_seen;

   function automatic bit [63:0] div_round_up(input bit [63:0] num, input bit [63:0] den);
      return num / den + (((num % den) != 64'd0) ? 64'd1 : 64'd0);
   endfunction

   function automatic bit [63:0] clip_wait(input bit [63:0] v);
      return (v > WAIT_CEIL) ? WAIT_CEIL : v;
   endfunction

   // P-K mean wait from the packets recorded so far; flag the clamp path
   function automatic bit [63:0] pk_mean_wait(output bit clamped);
      bit [63:0] twice_s;
      bit [63:0] whole;
      bit [63:0] rest;
      clamped = 1'b0;
      if (pkt_count == '0 || svc_total == 64'd0)
         return 64'd0;
      if (finish_max > svc_total)
         return clip_wait(div_round_up(svc_sq_total, 64'd2 * (finish_max - svc_total)));
      // overloaded: Q = whole * 2S + rest keeps 999 * Q inside 64 bits
      clamped = 1'b1;
      twice_s = 64'd2 * svc_total;
      whole   = svc_sq_total / twice_s;
      rest    = svc_sq_total % twice_s;
      if (whole > WAIT_CEIL)
         return WAIT_CEIL;
      return clip_wait(UTIL_NUM * whole + div_round_up(UTIL_NUM * rest, twice_s));
   endfunction

   task automatic report_mismatch(input string what, input bit [63:0] got,
                                  input bit [63:0] want);
      if (fail_count < PRINT_LIMIT)
         $display("[%0t] mismatch on result %0d, %s: got %0d, expected %0d",
                  $realtime, results_seen, what, got, want);
      fail_count++;
   endtask

   // predict the result word of one packet, then record the packet
   task automatic predict_packet(input mg1qde_req_type w);
      bit [63:0]      arr;
      bit [63:0]      svc;
      bit [63:0]      wait_cyc;
      bit [63:0]      sq;
      bit [63:0]      fin;
      bit             clamped;
      mg1qde_rsp_type rsp;
      arr = 64'(w.arrival_time[ARR_W-1:0]);
      svc = 64'(w.service_len);
      packets_seen++;
      // zero service length: flag it, leave the statistics alone
      if (svc == 64'd0) begin
         rsp.wait_estimate = '0;
         rsp.bad_input     = 1'b1;
         flagged_hits++;
         expected_rsp.push_back(rsp);
         return;
      end
      if (pkt_count == '0)
         empty_hits++;
      wait_cyc = pk_mean_wait(clamped);
      if (clamped)
         clamp_hits++;
      if (wait_cyc == WAIT_CEIL)
         sat_hits++;
      // record with saturation
      sq = svc * svc;
      svc_sq_total = (svc_sq_total > ~64'd0 - sq) ? ~64'd0 : svc_sq_total + sq;
      svc_total    = (svc_total > SUM_CEIL - svc) ? SUM_CEIL : svc_total + svc;
      if (pkt_count != '1)
         pkt_count++;
      fin = arr + wait_cyc + svc;
      if (fin > FINISH_CEIL)
         fin = FINISH_CEIL;
      if (fin > finish_max)
         finish_max = fin;
      rsp.wait_estimate = wait_cyc[WAIT_W-1:0];
      rsp.bad_input     = 1'b0;
      expected_rsp.push_back(rsp);
   endtask

   // watch both channels
   always @(posedge clock) begin
      if (reset) begin
         pkt_count    = '0;
         svc_total    = 64'd0;
         svc_sq_total = 64'd0;
         finish_max   = 64'd0;
         expected_rsp.delete();
         fail_count   = 0;
         packets_seen = 0;
         results_seen = 0;
         empty_hits   = 0;
         flagged_hits = 0;
         clamp_hits   = 0;
         sat_hits     = 0;
      end else begin
         if (req_valid && !req_stall)
            predict_packet(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("word with none expected", 64'(rsp_data.wait_estimate), 64'd0);
            end else begin
               due_rsp = expected_rsp.pop_front();
               if (rsp_data.wait_estimate !== due_rsp.wait_estimate)
                  report_mismatch("wait_estimate", 64'(rsp_data.wait_estimate),
                                  64'(due_rsp.wait_estimate));
               if (rsp_data.bad_input !== due_rsp.bad_input)
                  report_mismatch("bad_input", 64'(rsp_data.bad_input),
                                  64'(due_rsp.bad_input));
            end
            results_seen++;
         end
      end
      pending_words <= expected_rsp.size();
   end

endmodule : mg1qde_wait_checker

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the M/G/1 queue delay estimator
// Drives directed packets (empty history, zero length, overload clamp, field
// extremes), then random packet streams under several idling mixes and one
// long receiver hold. The checker predicts and compares; this module drives
// the channels and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import mg1qde_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 120;
   localparam int HOLD_CYCLES  = 600;
   localparam int HOLD_AT_WORD = 300;
   localparam int RANDOM_WORDS = 850;
   localparam int PHASES       = 4;

   logic           clock;
   logic           reset     = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_stall;
   mg1qde_req_type req_data  = '0;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   mg1qde_rsp_type rsp_data;

   int             sender_idle_pct    = 0;
   int             receiver_stall_pct = 0;
   logic           rsp_hold           = 1'b0;
   int             words_sent         = 0;
   int             cycle_count        = 0;
   bit [31:0]      arrival_clock      = '0;

   int             fail_count;
   int             pending_words;
   int             packets_seen;
   int             empty_hits;
   int             flagged_hits;
   int             clamp_hits;
   int             sat_hits;

   mg1_queue_delay_estimator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   mg1qde_wait_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .packets_seen  (packets_seen),
      .empty_hits    (empty_hits),
      .flagged_hits  (flagged_hits),
      .clamp_hits    (clamp_hits),
      .sat_hits      (sat_hits)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // random receiver stall, forced high during the long hold
   always @(posedge clock) begin
      rsp_stall <= rsp_hold || ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // long hold: the block fills up and stalls its input
   initial begin
      wait (words_sent >= HOLD_AT_WORD);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d words still expected",
                  cycle_count, pending_words);
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic mg1qde_req_type packet_word(input bit [31:0] arr, input bit [15:0] svc);
      mg1qde_req_type w;
      w.arrival_time = arr;
      w.service_len  = svc;
      return w;
   endfunction

   // next packet of a random stream; arrivals advance about one service apart
   function automatic mg1qde_req_type next_packet(input bit noisy);
      int        pick;
      bit [15:0] svc;
      bit [31:0] arr;
      pick = $urandom_range(0, 99);
      if (pick < 4)
         svc = '0;
      else if (pick < 14)
         svc = 16'($urandom_range(1, 8));
      else if (pick < 24)
         svc = 16'($urandom_range(60000, 65535));
      else if (pick < 60)
         svc = 16'($urandom_range(1, 2000));
      else
         svc = 16'($urandom_range(1, 65535));
      arrival_clock = arrival_clock + $urandom_range(0, 2 * svc + 16);
      arr = (noisy && $urandom_range(0, 9) == 0) ? $urandom() : arrival_clock;
      return packet_word(arr, svc);
   endfunction

   // offer one word, hold it until taken, then idle at random
   task automatic send_word(input mg1qde_req_type w);
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // drop valid and wait until every expected result has come
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   initial begin
      int phase;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero length on empty history, extremes, overload clamp
      send_word(packet_word(32'd0, 16'd0));
      send_word(packet_word(32'hFFFF_FFFF, 16'd0));
      send_word(packet_word(32'd0, 16'd100));
      send_word(packet_word(32'd0, 16'hFFFF));
      send_word(packet_word(32'd7, 16'd1));
      send_word(packet_word(32'h5555_5555, 16'd0));
      send_word(packet_word(32'd12, 16'hAAAA));
      send_word(packet_word(32'd20, 16'h5555));
      send_word(packet_word(32'd30, 16'h8000));
      send_word(packet_word(32'd40, 16'h0001));
      // back-to-back long packets let the service sum catch the finish time
      repeat (8) send_word(packet_word(32'd0, 16'hFFFF));
      send_word(packet_word(32'hAAAA_AAAA, 16'd0));
      drain_results();

      // random streams under each idling mix
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct     = 0;
               receiver_stall_pct <= 0;
            end
            1: begin
               sender_idle_pct     = 50;
               receiver_stall_pct <= 0;
            end
            2: begin
               sender_idle_pct     = 0;
               receiver_stall_pct <= 50;
            end
            default: begin
               sender_idle_pct     = 34;
               receiver_stall_pct <= 34;
            end
         endcase
         repeat (RANDOM_WORDS / PHASES) send_word(next_packet(phase == PHASES - 1));
         drain_results();
      end

      // largest arrival and service together
      send_word(packet_word(32'hFFFF_FFFF, 16'hFFFF));
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d packet words: %0d on empty history, %0d zero length, %0d clamped,",
               packets_seen, empty_hits, flagged_hits, clamp_hits);
      $display("%0d saturated; idle mixes none, sender, receiver, both, one long receiver hold.",
               sat_hits);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule : tb_top

FILE: sim.f
sv/mg1qde_pkg.sv
sv/mg1qde_ctrl.sv
sv/mg1qde_dp.sv
sv/mg1_queue_delay_estimator_top.sv
sim/mg1qde_wait_checker.sv
sim/tb_top.sv
